### rtl/core/sca_pkg.sv
package sca_pkg;

	// request codes
	localparam logic CMD_SCAN = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// set-1 scancodes of the modifier keys
	localparam logic [6:0] SC_LSHIFT = 7'h2A;
	localparam logic [6:0] SC_RSHIFT = 7'h36;
	localparam logic [6:0] SC_CTRL   = 7'h1D;
	localparam logic [6:0] SC_ALT    = 7'h38;

	localparam int unsigned CHAR_W = 7;

	localparam logic [CHAR_W-1:0] CH_CARET = 7'h5E;
	localparam logic [CHAR_W-1:0] CH_LOW_A = 7'h61;
	localparam logic [CHAR_W-1:0] CH_LOW_Z = 7'h7A;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 7'h41;
	localparam logic [CHAR_W-1:0] CH_UP_Z  = 7'h5A;
	localparam logic [CHAR_W-1:0] CH_CASE  = 7'h20;

	typedef struct packed {
		logic shift;
		logic ctrl;
		logic alt;
	} mods_t;

	typedef enum logic [1:0] {
		PUSH_NONE,
		PUSH_ONE,
		PUSH_CARET
	} push_t;

	typedef struct packed {
		mods_t              mods;
		push_t              push;
		logic [CHAR_W-1:0]  ch;
	} dec_t;

	function automatic logic [CHAR_W-1:0] plain_char(input logic [6:0] idx);
		logic [CHAR_W-1:0] c;
		case (idx)
			7'h01: c = 7'h1B;
			7'h02: c = 7'h31;
			7'h03: c = 7'h32;
			7'h04: c = 7'h33;
			7'h05: c = 7'h34;
			7'h06: c = 7'h35;
			7'h07: c = 7'h36;
			7'h08: c = 7'h37;
			7'h09: c = 7'h38;
			7'h0A: c = 7'h39;
			7'h0B: c = 7'h30;
			7'h0C: c = 7'h2D;
			7'h0D: c = 7'h3D;
			7'h0E: c = 7'h08;
			7'h0F: c = 7'h09;
			7'h10: c = 7'h71;
			7'h11: c = 7'h77;
			7'h12: c = 7'h65;
			7'h13: c = 7'h72;
			7'h14: c = 7'h74;
			7'h15: c = 7'h79;
			7'h16: c = 7'h75;
			7'h17: c = 7'h69;
			7'h18: c = 7'h6F;
			7'h19: c = 7'h70;
			7'h1A: c = 7'h5B;
			7'h1B: c = 7'h5D;
			7'h1C: c = 7'h0A;
			7'h1E: c = 7'h61;
			7'h1F: c = 7'h73;
			7'h20: c = 7'h64;
			7'h21: c = 7'h66;
			7'h22: c = 7'h67;
			7'h23: c = 7'h68;
			7'h24: c = 7'h6A;
			7'h25: c = 7'h6B;
			7'h26: c = 7'h6C;
			7'h27: c = 7'h3B;
			7'h28: c = 7'h27;
			7'h29: c = 7'h60;
			7'h2B: c = 7'h5C;
			7'h2C: c = 7'h7A;
			7'h2D: c = 7'h78;
			7'h2E: c = 7'h63;
			7'h2F: c = 7'h76;
			7'h30: c = 7'h62;
			7'h31: c = 7'h6E;
			7'h32: c = 7'h6D;
			7'h33: c = 7'h2C;
			7'h34: c = 7'h2E;
			7'h35: c = 7'h2F;
			7'h37: c = 7'h2A;
			7'h39: c = 7'h20;
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] shift_char(input logic [6:0] idx);
		logic [CHAR_W-1:0] c;
		case (idx)
			7'h01: c = 7'h1B;
			7'h02: c = 7'h21;
			7'h03: c = 7'h40;
			7'h04: c = 7'h23;
			7'h05: c = 7'h24;
			7'h06: c = 7'h25;
			7'h07: c = 7'h5E;
			7'h08: c = 7'h26;
			7'h09: c = 7'h2A;
			7'h0A: c = 7'h28;
			7'h0B: c = 7'h29;
			7'h0C: c = 7'h5F;
			7'h0D: c = 7'h2B;
			7'h0E: c = 7'h08;
			7'h0F: c = 7'h09;
			7'h10: c = 7'h51;
			7'h11: c = 7'h57;
			7'h12: c = 7'h45;
			7'h13: c = 7'h52;
			7'h14: c = 7'h54;
			7'h15: c = 7'h59;
			7'h16: c = 7'h55;
			7'h17: c = 7'h49;
			7'h18: c = 7'h4F;
			7'h19: c = 7'h50;
			7'h1A: c = 7'h7B;
			7'h1B: c = 7'h7D;
			7'h1C: c = 7'h0A;
			7'h1E: c = 7'h41;
			7'h1F: c = 7'h53;
			7'h20: c = 7'h44;
			7'h21: c = 7'h46;
			7'h22: c = 7'h47;
			7'h23: c = 7'h48;
			7'h24: c = 7'h4A;
			7'h25: c = 7'h4B;
			7'h26: c = 7'h4C;
			7'h27: c = 7'h3A;
			7'h28: c = 7'h22;
			7'h29: c = 7'h7E;
			7'h2B: c = 7'h7C;
			7'h2C: c = 7'h5A;
			7'h2D: c = 7'h58;
			7'h2E: c = 7'h43;
			7'h2F: c = 7'h56;
			7'h30: c = 7'h42;
			7'h31: c = 7'h4E;
			7'h32: c = 7'h4D;
			7'h33: c = 7'h3C;
			7'h34: c = 7'h3E;
			7'h35: c = 7'h3F;
			7'h37: c = 7'h2A;
			7'h39: c = 7'h20;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

### rtl/core/sca_ram.sv
module sca_ram #(
	parameter int unsigned WIDTH = 7,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/sca_decode.sv
module sca_decode (
	input  logic [7:0]     code,
	input  sca_pkg::mods_t mods,
	output sca_pkg::dec_t  dec
);

	logic [6:0]                   base;
	logic [sca_pkg::CHAR_W-1:0]   look;
	logic [sca_pkg::CHAR_W-1:0]   upper;

	assign base = code[6:0];

	always_comb begin
		look  = mods.shift ? sca_pkg::shift_char(base) : sca_pkg::plain_char(base);
		upper = look;
		if (look inside {[sca_pkg::CH_LOW_A:sca_pkg::CH_LOW_Z]}) begin
			upper = look - sca_pkg::CH_CASE;
		end

		dec.mods = mods;
		dec.push = sca_pkg::PUSH_NONE;
		dec.ch   = look;

		if (code[7]) begin
			// release: only modifiers matter
			if (base == sca_pkg::SC_LSHIFT || base == sca_pkg::SC_RSHIFT) begin
				dec.mods.shift = 1'b0;
			end else if (base == sca_pkg::SC_CTRL) begin
				dec.mods.ctrl = 1'b0;
			end else if (base == sca_pkg::SC_ALT) begin
				dec.mods.alt = 1'b0;
			end
		end else if (base == sca_pkg::SC_LSHIFT || base == sca_pkg::SC_RSHIFT) begin
			dec.mods.shift = 1'b1;
		end else if (base == sca_pkg::SC_CTRL) begin
			dec.mods.ctrl = 1'b1;
		end else if (base == sca_pkg::SC_ALT) begin
			dec.mods.alt = 1'b1;
		end else if (look != '0) begin
			if (mods.ctrl) begin
				// ctrl-letter becomes caret plus capital
				dec.ch = upper;
				if (upper inside {[sca_pkg::CH_UP_A:sca_pkg::CH_UP_Z]}) begin
					dec.push = sca_pkg::PUSH_CARET;
				end
			end else if (!mods.alt) begin
				dec.push = sca_pkg::PUSH_ONE;
			end
		end
	end

endmodule

### rtl/core/scancode_to_ascii_fifo.sv
// PS/2 set-1 scancode to ASCII converter with a character queue
//
// input channel (in_valid/in_ready): one request per handshake, cmd selects
// a scancode event or a read of one character; scancode is ignored on a read
// output channel (out_valid/out_ready): exactly one result per request, in
// order: char_out (popped character, 0 on an event or an empty queue),
// fifo_count (characters held afterwards) and dropped (a push was lost)
// each request is registered in the request stage, its result in the output
// register; a ctrl-letter stays in the request stage while it writes caret and
// capital in turn through the single write port of the character store
// throughput: one request per cycle, except during a stall or a caret write
// the queue holds at most FIFO_DEPTH-1 characters; a push into a full queue
// is lost and flagged
// reset: read and write pointers and the modifier flags clear at once; the
// store needs no clearing pass, an entry is read only after it was written
// receiver stall: the result waits in the output register, the stage before it
// still takes one request; in_ready falls when both are full or a caret is written
module scancode_to_ascii_fifo #(
	parameter int unsigned FIFO_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cmd,
	input  logic [7:0] scancode,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] char_out,
	output logic [7:0] fifo_count,
	output logic       dropped
);

	localparam int unsigned PW = $clog2(FIFO_DEPTH);
	localparam int unsigned XW = (PW > 8) ? PW : 8;

	// request stage
	logic       s1_valid_q;
	logic       cmd_s1;
	logic [7:0] code_s1;
	logic       phase_q;   // caret already handled for a ctrl-letter
	logic       lost_q;    // caret push was lost

	// queue and modifier state
	logic [PW-1:0]  rd_q;
	logic [PW-1:0]  wr_q;
	sca_pkg::mods_t mods_q;

	// result stage
	logic          pop_s2;
	logic [7:0]    count_s2;
	logic          lost_s2;
	logic [6:0]    rdata;

	sca_pkg::dec_t dec;

	logic          s2_free;
	logic          s1_go;
	logic          caret_first;
	logic          s1_adv;
	logic          push_req;
	logic          full;
	logic          empty;
	logic          do_push;
	logic          do_pop;
	logic          lost_now;
	logic [6:0]    wdata;
	logic [PW-1:0] rd_inc;
	logic [PW-1:0] wr_inc;
	logic [PW-1:0] rd_n;
	logic [PW-1:0] wr_n;
	logic [PW:0]   diff;
	logic [PW:0]   level;
	logic [XW-1:0] level_x;
	logic [7:0]    count_n;

	sca_decode u_decode (
		.code (code_s1),
		.mods (mods_q),
		.dec  (dec)
	);

	// pointer arithmetic, wrap at the queue depth
	assign rd_inc = (rd_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_q + PW'(1);
	assign wr_inc = (wr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_q + PW'(1);
	assign full   = (wr_inc == rd_q);
	assign empty  = (rd_q == wr_q);

	// handshakes
	assign s2_free     = !out_valid || out_ready;
	assign s1_go       = s1_valid_q && s2_free;
	assign caret_first = (cmd_s1 == sca_pkg::CMD_SCAN) && (dec.push == sca_pkg::PUSH_CARET)
		&& !phase_q;
	assign s1_adv      = s1_go && !caret_first;
	assign in_ready    = !s1_valid_q || s1_adv;

	// store access
	assign push_req = s1_go && (cmd_s1 == sca_pkg::CMD_SCAN)
		&& (dec.push == sca_pkg::PUSH_ONE || dec.push == sca_pkg::PUSH_CARET);
	assign do_push  = push_req && !full;
	assign lost_now = push_req && full;
	assign do_pop   = s1_go && (cmd_s1 == sca_pkg::CMD_READ) && !empty;
	assign wdata    = caret_first ? sca_pkg::CH_CARET : dec.ch;

	assign rd_n = do_pop  ? rd_inc : rd_q;
	assign wr_n = do_push ? wr_inc : wr_q;

	// level after this step, saturating at the width of fifo_count
	always_comb begin
		diff    = {1'b0, wr_n} - {1'b0, rd_n};
		level   = diff[PW] ? diff + (PW + 1)'(FIFO_DEPTH) : diff;
		level_x = XW'(level[PW-1:0]);
		count_n = (level_x > XW'(255)) ? 8'hFF : level_x[7:0];
	end

	sca_ram #(
		.WIDTH (sca_pkg::CHAR_W),
		.DEPTH (FIFO_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (do_push),
		.waddr (wr_q),
		.wdata (wdata),
		.re    (do_pop),
		.raddr (rd_q),
		.rdata (rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			phase_q    <= 1'b0;
			lost_q     <= 1'b0;
			rd_q       <= '0;
			wr_q       <= '0;
			mods_q     <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (in_ready) begin
				s1_valid_q <= in_valid;
			end
			if (s1_go) begin
				rd_q <= rd_n;
				wr_q <= wr_n;
				if (caret_first) begin
					phase_q <= 1'b1;
					lost_q  <= lost_now;
				end else begin
					phase_q <= 1'b0;
					lost_q  <= 1'b0;
				end
				if (cmd_s1 == sca_pkg::CMD_SCAN) begin
					mods_q <= dec.mods;
				end
			end
			if (s2_free) begin
				out_valid <= s1_adv;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= cmd;
			code_s1 <= scancode;
		end
		if (s1_adv) begin
			pop_s2   <= do_pop;
			count_s2 <= count_n;
			lost_s2  <= lost_now || (phase_q && lost_q);
		end
	end

	// read data stays in the store's output register while the result waits
	assign char_out   = pop_s2 ? rdata : '0;
	assign fifo_count = count_s2;
	assign dropped    = lost_s2;

	// a ctrl-letter only sits in its second half while its request is held
	a_phase_held: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> s1_valid_q)
		else $error("caret phase without a held request");

	// a caret phase never outlives the request it belongs to
	a_phase_done: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> !phase_q)
		else $error("caret phase survived its request");

	// a result never both pops a character and reports a lost push
	a_pop_xor_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> char_out == '0)
		else $error("dropped push reported on a read");

	// the queue never appears to hold FIFO_DEPTH characters
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |-> wr_inc != rd_q)
		else $error("push into a full queue");

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

// tracks modifier state and the character queue, and holds the result owed for
// every request that the block has taken
class char_tracker #(int DEPTH = 256);

	typedef struct packed {
		bit [6:0] ch;
		bit [7:0] count;
		bit       drop;
	} outcome_t;

	bit [6:0] plain_map [128];
	bit [6:0] shift_map [128];
	bit [6:0] held_chars [$];
	outcome_t awaited [$];
	bit shift_on, ctrl_on, alt_on;
	int errors;
	int drops;

	function new();
		bit [6:0] plain_rows [58] = '{
			7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
			7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
			7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
			7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
			7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
			7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20};
		bit [6:0] shift_rows [58] = '{
			7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
			7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
			7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
			7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
			7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
			7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20};
		foreach (plain_map[i]) begin
			plain_map[i] = (i < 58) ? plain_rows[i] : 7'h00;
			shift_map[i] = (i < 58) ? shift_rows[i] : 7'h00;
		end
	endfunction

	// one slot always stays free
	function bit store_char(bit [6:0] c);
		if (held_chars.size() >= DEPTH - 1)
			return 1'b0;
		held_chars.push_back(c);
		return 1'b1;
	endfunction

	function int level();
		return held_chars.size();
	endfunction

	function int pending();
		return awaited.size();
	endfunction

	function void note_request(bit c, bit [7:0] sc);
		outcome_t o;
		bit [6:0] key, ch;
		o = '0;
		key = sc[6:0];
		if (c == sca_pkg::CMD_READ) begin
			if (held_chars.size() > 0)
				o.ch = held_chars.pop_front();
		end else if (sc[7]) begin
			// releases only matter for modifiers
			if (key == sca_pkg::SC_LSHIFT || key == sca_pkg::SC_RSHIFT)
				shift_on = 1'b0;
			else if (key == sca_pkg::SC_CTRL)
				ctrl_on = 1'b0;
			else if (key == sca_pkg::SC_ALT)
				alt_on = 1'b0;
		end else if (key == sca_pkg::SC_LSHIFT || key == sca_pkg::SC_RSHIFT) begin
			shift_on = 1'b1;
		end else if (key == sca_pkg::SC_CTRL) begin
			ctrl_on = 1'b1;
		end else if (key == sca_pkg::SC_ALT) begin
			alt_on = 1'b1;
		end else begin
			ch = shift_on ? shift_map[key] : plain_map[key];
			if (ch != 7'h00) begin
				if (ctrl_on) begin
					if (ch >= sca_pkg::CH_LOW_A && ch <= sca_pkg::CH_LOW_Z)
						ch = ch - sca_pkg::CH_CASE;
					if (ch >= sca_pkg::CH_UP_A && ch <= sca_pkg::CH_UP_Z) begin
						if (!store_char(sca_pkg::CH_CARET))
							o.drop = 1'b1;
						if (!store_char(ch))
							o.drop = 1'b1;
					end
				end else if (!alt_on) begin
					o.drop = !store_char(ch);
				end
			end
		end
		o.count = (held_chars.size() > 255) ? 8'd255 : 8'(held_chars.size());
		if (o.drop)
			drops++;
		awaited.push_back(o);
	endfunction

	function void check_result(logic [6:0] ch, logic [7:0] count, logic drop);
		outcome_t want;
		if (awaited.size() == 0) begin
			$error("result with no request outstanding: char_out %0h fifo_count %0d",
				ch, count);
			errors++;
			return;
		end
		want = awaited.pop_front();
		if (ch !== want.ch) begin
			$error("char_out: expected %0h, got %0h", want.ch, ch);
			errors++;
		end
		if (count !== want.count) begin
			$error("fifo_count: expected %0d, got %0d", want.count, count);
			errors++;
		end
		if (drop !== want.drop) begin
			$error("dropped: expected %0b, got %0b", want.drop, drop);
			errors++;
		end
	endfunction

endclass

module tb_top;

	localparam int QUEUE_DEPTH = 256;
	localparam int ITEMS       = 1400;
	localparam int MAX_GAP     = 18;
	localparam int LONG_HOLD   = 300;  // receiver hold-off, long enough to back up the input
	localparam int QUIET_LIMIT = 2000; // cycles with no handshake on either side
	localparam int DRAIN_WAIT  = 8;

	// opening requests: empty read, ignored codes, both shifts, ctrl with a letter and a
	// non-letter, ctrl and alt together, alt alone, prefix bytes, out-of-table code
	localparam bit [8:0] OPENING [23] = '{
		{sca_pkg::CMD_READ, 8'hFF}, {sca_pkg::CMD_SCAN, 8'h00}, {sca_pkg::CMD_SCAN, 8'h1E},
		{sca_pkg::CMD_SCAN, 8'h9E}, {sca_pkg::CMD_SCAN, 8'h2A}, {sca_pkg::CMD_SCAN, 8'h1E},
		{sca_pkg::CMD_SCAN, 8'hAA}, {sca_pkg::CMD_SCAN, 8'h36}, {sca_pkg::CMD_SCAN, 8'h02},
		{sca_pkg::CMD_SCAN, 8'hB6}, {sca_pkg::CMD_SCAN, 8'h1D}, {sca_pkg::CMD_SCAN, 8'h2E},
		{sca_pkg::CMD_SCAN, 8'h02}, {sca_pkg::CMD_SCAN, 8'h38}, {sca_pkg::CMD_SCAN, 8'h1F},
		{sca_pkg::CMD_SCAN, 8'h9D}, {sca_pkg::CMD_SCAN, 8'h1E}, {sca_pkg::CMD_SCAN, 8'hB8},
		{sca_pkg::CMD_SCAN, 8'hE0}, {sca_pkg::CMD_SCAN, 8'hE1}, {sca_pkg::CMD_SCAN, 8'h7F},
		{sca_pkg::CMD_SCAN, 8'h39}, {sca_pkg::CMD_READ, 8'h00}};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       cmd = sca_pkg::CMD_SCAN;
	logic [7:0] scancode = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [6:0] char_out;
	logic [7:0] fifo_count;
	logic       dropped;

	char_tracker #(QUEUE_DEPTH) book;

	int sent;
	int read_pct;         // chance of slipping reads in before a key event
	int send_run, recv_run;
	int quiet_cycles;
	bit hold_off;         // asks the receiver for one long stall

	scancode_to_ascii_fifo #(
		.FIFO_DEPTH(QUEUE_DEPTH)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.scancode  (scancode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_out  (char_out),
		.fifo_count(fifo_count),
		.dropped   (dropped)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// idle length per request; now and then a run of back-to-back requests
	function automatic int draw_gap(ref int run_left);
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			run_left = $urandom_range(10, 40);
		return $urandom_range(0, MAX_GAP);
	endfunction

	// offer one request; valid stays up across back-to-back requests
	task automatic send_request(input logic c, input logic [7:0] sc);
		int gap;
		gap = draw_gap(send_run);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		scancode <= sc;
		do @(posedge clk); while (!in_ready);
		// noted here rather than in a monitor so the generator sees the fill level at once
		book.note_request(c, sc);
		sent++;
	endtask

	task automatic key_event(input logic [7:0] sc);
		if ($urandom_range(0, 99) < read_pct)
			repeat ($urandom_range(1, 3))
				send_request(sca_pkg::CMD_READ, 8'($urandom_range(0, 255)));
		send_request(sca_pkg::CMD_SCAN, sc);
	endtask

	task automatic tap(input logic [6:0] key);
		key_event({1'b0, key});
		key_event({1'b1, key});
	endtask

	function automatic logic [6:0] pick_key();
		if ($urandom_range(0, 4) == 0)
			return 7'($urandom_range(0, 127));
		return 7'($urandom_range(1, 7'h39));
	endfunction

	// letter keys sit in three rows of the set-1 layout
	function automatic logic [6:0] pick_letter();
		int r;
		r = $urandom_range(0, 25);
		if (r < 10)
			return 7'(7'h10 + r);
		if (r < 19)
			return 7'(7'h1E + r - 10);
		return 7'(7'h2C + r - 19);
	endfunction

	function automatic logic [6:0] pick_modifier();
		case ($urandom_range(0, 3))
			0: return sca_pkg::SC_LSHIFT;
			1: return sca_pkg::SC_RSHIFT;
			2: return sca_pkg::SC_CTRL;
			default: return sca_pkg::SC_ALT;
		endcase
	endfunction

	// one typing gesture: mostly well formed, the rest noise and half sequences
	task automatic play_sequence();
		int kind;
		logic [6:0] key, modkey;
		kind = $urandom_range(0, 99);
		// one free slot left: a ctrl-letter here stores the caret and loses the letter
		if (book.level() == QUEUE_DEPTH - 2 && kind < 50)
			kind = 70;
		if (kind < 30) begin
			tap(pick_key());
		end else if (kind < 40) begin
			// typematic repeat: make code sent again and again while held
			key = pick_key();
			repeat ($urandom_range(2, 20)) key_event({1'b0, key});
			key_event({1'b1, key});
		end else if (kind < 55) begin
			modkey = $urandom_range(0, 1) ? sca_pkg::SC_LSHIFT : sca_pkg::SC_RSHIFT;
			key_event({1'b0, modkey});
			repeat ($urandom_range(1, 3)) tap(pick_key());
			key_event({1'b1, modkey});
		end else if (kind < 70) begin
			key_event({1'b0, sca_pkg::SC_ALT});
			repeat ($urandom_range(1, 2)) tap(pick_key());
			key_event({1'b1, sca_pkg::SC_ALT});
		end else if (kind < 85) begin
			key_event({1'b0, sca_pkg::SC_CTRL});
			if ($urandom_range(0, 3) == 0)
				key_event({1'b0, sca_pkg::SC_LSHIFT});
			repeat ($urandom_range(1, 2))
				tap($urandom_range(0, 3) == 0 ? pick_key() : pick_letter());
			key_event({1'b1, sca_pkg::SC_LSHIFT});
			key_event({1'b1, sca_pkg::SC_CTRL});
		end else begin
			case ($urandom_range(0, 3))
				0: key_event(8'($urandom_range(0, 255)));
				1: key_event({1'($urandom_range(0, 1)), pick_modifier()});
				2: begin
					key_event(8'hE0);
					tap(pick_key());
				end
				default: send_request(sca_pkg::CMD_READ, 8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	// receiver: random stalls per result, plus the long hold-off when asked
	initial begin
		int gap;
		forever begin
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_off = 1'b0;
			end else begin
				gap = draw_gap(recv_run);
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				out_ready <= 1'b1;
				do @(posedge clk); while (!out_valid);
			end
		end
	end

	// result checking and the no-progress watchdog
	always @(posedge clk) begin
		if (out_valid && out_ready)
			book.check_result(char_out, fifo_count, dropped);
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		book = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		read_pct = 0;
		foreach (OPENING[i])
			send_request(OPENING[i][8], OPENING[i][7:0]);

		// fill to overflow with the receiver held off, so the input backs up too
		hold_off = 1'b1;
		read_pct = 2;
		for (int k = 0; k < 600 && book.drops < 25; k++)
			play_sequence();

		// phases alternate between filling, mixed traffic and draining
		while (sent < ITEMS) begin
			case ($urandom_range(0, 3))
				0: read_pct = 3;
				1: read_pct = 20;
				2: read_pct = 45;
				default: read_pct = 80;
			endcase
			if ($urandom_range(0, 5) == 0)
				hold_off = 1'b1;
			repeat ($urandom_range(15, 50)) play_sequence();
		end
		in_valid <= 1'b0;

		while (book.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (book.errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
